@@ sv/sjr_pkg.sv @@
`timescale 1ns / 1ps

package sjr_pkg;

  // Fixed-point units.
  localparam int unsigned ONE_Q14 = 16384;
  localparam int unsigned ONE_Q16 = 65536;

  // Action codes of an input beat.
  localparam logic [1:0] ACT_LINE   = 2'd0;
  localparam logic [1:0] ACT_NOLINE = 2'd1;
  localparam logic [1:0] ACT_CLEAR  = 2'd2;

  // Configuration register indexes.
  localparam logic [2:0] CFG_MODE      = 3'd0;
  localparam logic [2:0] CFG_MAX_JUMP  = 3'd1;
  localparam logic [2:0] CFG_COS_ANGLE = 3'd2;
  localparam logic [2:0] CFG_MAX_REJ   = 3'd3;
  localparam logic [2:0] CFG_PT_ALPHA  = 3'd4;
  localparam logic [2:0] CFG_DIR_ALPHA = 3'd5;

  // Register reset values.
  localparam logic [2:0]         RST_MODE      = 3'd3;
  localparam logic [30:0]        RST_MAX_JUMP  = 31'd32768;
  localparam logic signed [15:0] RST_COS_ANGLE = 16'sd16135;
  localparam logic [7:0]         RST_MAX_REJ   = 8'd5;
  localparam logic [16:0]        RST_ALPHA     = 17'd19661;

  // Mode flag bit positions.
  localparam int unsigned MODE_REJECT = 0;
  localparam int unsigned MODE_SMOOTH = 1;
  localparam int unsigned MODE_FORCE  = 2;

  // Iteration counts of the root and divide units.
  localparam int unsigned SQRT_STEPS = 32;
  localparam int unsigned DIV_STEPS  = 15;

endpackage

@@ sv/sjr_isqrt.sv @@
`timescale 1ns / 1ps

// Integer square root of a 64-bit radicand, one result bit per cycle.
module sjr_isqrt (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] radicand,
  output logic        done,
  output logic [31:0] root
);

  logic [63:0] s_r;
  logic [63:0] r_r;
  logic [63:0] bit_r;
  logic [4:0]  cnt_r;
  logic        busy_r;
  logic        done_r;
  logic [63:0] trial;

  assign trial = r_r + bit_r;
  assign done  = done_r;
  assign root  = r_r[31:0];

  // Digit-by-digit root: the test bit walks down two places a cycle.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        s_r    <= radicand;
        r_r    <= '0;
        bit_r  <= 64'h4000_0000_0000_0000;
        cnt_r  <= '0;
        busy_r <= 1'b1;
      end else if (busy_r) begin
        if (s_r >= trial) begin
          s_r <= s_r - trial;
          r_r <= (r_r >> 1) + bit_r;
        end else begin
          r_r <= r_r >> 1;
        end
        bit_r <= bit_r >> 2;
        cnt_r <= cnt_r + 5'd1;
        if (cnt_r == 5'(sjr_pkg::SQRT_STEPS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

endmodule

@@ sv/axis_smoothing_jump_reject_core.sv @@
`timescale 1ns / 1ps

// Line smoother with jump rejection. Each input beat carries a fitted 3D line
// (Q15.16 point, Q1.14 unit direction), a frame without a line, or a clear,
// and produces exactly one result beat. A clear or no-line beat goes straight
// to the result; a line is first checked for a jump when rejection is on and a
// line is held, and a smoothed line is then blended and renormalized. The time
// is set by one shared 33x33 multiplier used for every product in turn, a
// 32-step square root and three 15-step divisions that renormalize the
// direction. A result also waits while the result register stays full. The
// input is not ready while a beat is being worked on. The configuration port
// is always ready and is meant to be written while the block is idle.
module axis_smoothing_jump_reject_core (
  input  logic               clk,
  input  logic               rst_n,
  // configuration
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  // input beats
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_action,
  input  logic signed [31:0] in_new_point_x,
  input  logic signed [31:0] in_new_point_y,
  input  logic signed [31:0] in_new_point_z,
  input  logic signed [15:0] in_new_dir_x,
  input  logic signed [15:0] in_new_dir_y,
  input  logic signed [15:0] in_new_dir_z,
  input  logic [15:0]        in_new_inliers,
  // result beats
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_success,
  output logic               out_jump_flag,
  output logic signed [31:0] out_point_x,
  output logic signed [31:0] out_point_y,
  output logic signed [31:0] out_point_z,
  output logic signed [15:0] out_dir_x,
  output logic signed [15:0] out_dir_y,
  output logic [14:0]        out_dir_z,
  output logic [14:0]        out_vertical_cos,
  output logic [15:0]        out_inliers,
  output logic [7:0]         out_reject_count
);

  typedef enum logic [4:0] {
    S_IDLE, S_LAT, S_LAT_ACC, S_MAXSQ, S_MAXSQ_ACC, S_DOT, S_DOT_ACC,
    S_DECIDE, S_PB0, S_PB1, S_PB2, S_DB0, S_DB1, S_DB2, S_BZERO,
    S_SSQ, S_SSQ_ACC, S_SQRT, S_SQRT_WAIT, S_DIV_INIT, S_DIV, S_DIV_END,
    S_FIX, S_EMIT
  } state_t;

  state_t state_r;
  logic [1:0] idx_r;

  // Configuration registers.
  logic [2:0]         mode_r;
  logic [30:0]        max_jump_r;
  logic signed [15:0] cos_angle_r;
  logic [7:0]         max_rej_r;
  logic [16:0]        pt_alpha_r;
  logic [16:0]        dir_alpha_r;

  // Held line.
  logic signed [31:0] hp_r [3];
  logic signed [15:0] hd_r [3];
  logic [15:0]        hinl_r;
  logic               has_line_r;
  logic [7:0]         rej_cnt_r;

  // Latched input beat.
  logic signed [31:0] np_r [3];
  logic signed [15:0] nd_r [3];
  logic [15:0]        ninl_r;

  // Working registers.
  logic signed [65:0] prod_r;
  logic [63:0]        ss_r;
  logic               lat_bad_r;
  logic signed [31:0] dot_r;
  logic signed [49:0] acc_r;
  logic signed [31:0] b_r [3];
  logic [31:0]        n_r;
  logic [45:0]        rem_r;
  logic [45:0]        den_r;
  logic [14:0]        q_r;
  logic [3:0]         dcnt_r;
  logic               jump_r;

  logic signed [32:0] mul_a;
  logic signed [32:0] mul_b;
  logic signed [32:0] lat_d;
  logic [31:0]        lat_a;
  logic [16:0]        pa_s;
  logic [16:0]        da_s;
  logic [16:0]        pa_inv;
  logic [16:0]        da_inv;
  logic signed [15:0] nd_sat [3];
  logic signed [15:0] nd_up [3];
  logic signed [31:0] dot_c;
  logic signed [31:0] cos_lim;
  logic               bad;
  logic [7:0]         cnt_bump;
  logic signed [49:0] blend_sum;
  logic signed [31:0] b_abs;
  logic               sqrt_start;
  logic               sqrt_done;
  logic [31:0]        sqrt_root;
  logic               last_idx;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state_r == S_IDLE);
  assign last_idx  = (idx_r == 2'd2);

  function automatic logic signed [15:0] sjr_sat_dir(input logic signed [15:0] v);
    if (v > 16'sd16384) return 16'sd16384;
    if (v < -16'sd16384) return -16'sd16384;
    return v;
  endfunction

  // Saturate incoming direction and turn it upward for a direct take.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      nd_sat[i] = 16'(sjr_sat_dir(i == 0 ? in_new_dir_x :
                                  i == 1 ? in_new_dir_y : in_new_dir_z));
      nd_up[i]  = nd_r[2][15] ? -nd_r[i] : nd_r[i];
    end
  end

  // Alpha saturation and complements.
  assign pa_s   = (pt_alpha_r > 17'(sjr_pkg::ONE_Q16)) ? 17'(sjr_pkg::ONE_Q16) : pt_alpha_r;
  assign da_s   = (dir_alpha_r > 17'(sjr_pkg::ONE_Q16)) ? 17'(sjr_pkg::ONE_Q16) : dir_alpha_r;
  assign pa_inv = 17'(sjr_pkg::ONE_Q16) - pa_s;
  assign da_inv = 17'(sjr_pkg::ONE_Q16) - da_s;

  // Point displacement of the current component.
  assign lat_d = {np_r[idx_r][31], np_r[idx_r]} - {hp_r[idx_r][31], hp_r[idx_r]};
  assign lat_a = lat_d[32] ? 32'(-lat_d) : lat_d[31:0];

  // Clamped direction dot product against the cosine limit.
  always_comb begin
    if (dot_r > 32'sd268435456) dot_c = 32'sd268435456;
    else if (dot_r < -32'sd268435456) dot_c = -32'sd268435456;
    else dot_c = dot_r;
  end
  assign cos_lim  = {{2{cos_angle_r[15]}}, cos_angle_r, 14'd0};
  assign bad      = mode_r[sjr_pkg::MODE_REJECT] & (lat_bad_r | (dot_c < cos_lim));
  assign cnt_bump = (rej_cnt_r == 8'd255) ? 8'd255 : rej_cnt_r + 8'd1;

  assign blend_sum = acc_r + prod_r[49:0];
  assign b_abs     = b_r[idx_r][31] ? -b_r[idx_r] : b_r[idx_r];

  // Operand select for the shared multiplier.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_r)
      S_LAT: begin
        mul_a = {1'b0, lat_a};
        mul_b = {1'b0, lat_a};
      end
      S_MAXSQ: begin
        mul_a = {2'b0, max_jump_r};
        mul_b = {2'b0, max_jump_r};
      end
      S_DOT: begin
        mul_a = {{17{nd_r[idx_r][15]}}, nd_r[idx_r]};
        mul_b = {{17{hd_r[idx_r][15]}}, hd_r[idx_r]};
      end
      S_PB0: begin
        mul_a = {hp_r[idx_r][31], hp_r[idx_r]};
        mul_b = {16'd0, pa_inv};
      end
      S_PB1: begin
        mul_a = {np_r[idx_r][31], np_r[idx_r]};
        mul_b = {16'd0, pa_s};
      end
      S_DB0: begin
        mul_a = {{17{hd_r[idx_r][15]}}, hd_r[idx_r]};
        mul_b = {16'd0, da_inv};
      end
      S_DB1: begin
        mul_a = {{17{nd_r[idx_r][15]}}, nd_r[idx_r]};
        mul_b = {16'd0, da_s};
      end
      S_SSQ: begin
        mul_a = {b_r[idx_r][31], b_r[idx_r]};
        mul_b = {b_r[idx_r][31], b_r[idx_r]};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign sqrt_start = (state_r == S_SQRT);

  sjr_isqrt u_isqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (sqrt_start),
    .radicand (ss_r),
    .done     (sqrt_done),
    .root     (sqrt_root)
  );

  // Sequencer, datapath registers and the output register.
  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
    if (!rst_n) begin
      state_r     <= S_IDLE;
      idx_r       <= '0;
      mode_r      <= sjr_pkg::RST_MODE;
      max_jump_r  <= sjr_pkg::RST_MAX_JUMP;
      cos_angle_r <= sjr_pkg::RST_COS_ANGLE;
      max_rej_r   <= sjr_pkg::RST_MAX_REJ;
      pt_alpha_r  <= sjr_pkg::RST_ALPHA;
      dir_alpha_r <= sjr_pkg::RST_ALPHA;
      for (int i = 0; i < 3; i++) begin
        hp_r[i] <= '0;
        hd_r[i] <= '0;
      end
      hinl_r     <= '0;
      has_line_r <= 1'b0;
      rej_cnt_r  <= '0;
      out_valid  <= 1'b0;
    end else begin
      // Configuration writes.
      if (cfg_valid) begin
        unique case (cfg_index)
          sjr_pkg::CFG_MODE:      mode_r      <= cfg_data[2:0];
          sjr_pkg::CFG_MAX_JUMP:  max_jump_r  <= cfg_data[30:0];
          sjr_pkg::CFG_COS_ANGLE: cos_angle_r <= cfg_data[15:0];
          sjr_pkg::CFG_MAX_REJ:   max_rej_r   <= cfg_data[7:0];
          sjr_pkg::CFG_PT_ALPHA:  pt_alpha_r  <= cfg_data[16:0];
          sjr_pkg::CFG_DIR_ALPHA: dir_alpha_r <= cfg_data[16:0];
          default: ;
        endcase
      end

      // A taken result empties the register unless a new one is loaded now.
      if (out_valid && out_ready && state_r != S_EMIT) out_valid <= 1'b0;

      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            np_r[0] <= in_new_point_x;
            np_r[1] <= in_new_point_y;
            np_r[2] <= in_new_point_z;
            for (int i = 0; i < 3; i++) nd_r[i] <= nd_sat[i];
            ninl_r    <= in_new_inliers;
            jump_r    <= 1'b0;
            idx_r     <= '0;
            ss_r      <= '0;
            dot_r     <= '0;
            lat_bad_r <= 1'b0;
            case (in_action)
              sjr_pkg::ACT_CLEAR: begin
                for (int i = 0; i < 3; i++) begin
                  hp_r[i] <= '0;
                  hd_r[i] <= '0;
                end
                hinl_r     <= '0;
                has_line_r <= 1'b0;
                rej_cnt_r  <= '0;
                state_r    <= S_EMIT;
              end
              sjr_pkg::ACT_LINE: begin
                if (!has_line_r) state_r <= S_DECIDE;
                else if (mode_r[sjr_pkg::MODE_REJECT]) state_r <= S_LAT;
                else state_r <= S_DECIDE;
              end
              default: begin
                rej_cnt_r <= cnt_bump;
                state_r   <= S_EMIT;
              end
            endcase
          end
        end

        // Squared lateral distance, component by component.
        S_LAT: state_r <= S_LAT_ACC;
        S_LAT_ACC: begin
          if (lat_a > {1'b0, max_jump_r}) lat_bad_r <= 1'b1;
          else ss_r <= ss_r + prod_r[63:0];
          idx_r   <= last_idx ? 2'd0 : idx_r + 2'd1;
          state_r <= last_idx ? S_MAXSQ : S_LAT;
        end
        S_MAXSQ: state_r <= S_MAXSQ_ACC;
        S_MAXSQ_ACC: begin
          if (ss_r > prod_r[63:0]) lat_bad_r <= 1'b1;
          idx_r   <= '0;
          state_r <= S_DOT;
        end

        // Direction dot product.
        S_DOT: state_r <= S_DOT_ACC;
        S_DOT_ACC: begin
          dot_r   <= dot_r + prod_r[31:0];
          idx_r   <= last_idx ? 2'd0 : idx_r + 2'd1;
          state_r <= last_idx ? S_DECIDE : S_DOT;
        end

        // First line, rejection, adoption or blending.
        S_DECIDE: begin
          idx_r <= '0;
          if (!has_line_r) begin
            for (int i = 0; i < 3; i++) begin
              hp_r[i] <= np_r[i];
              hd_r[i] <= nd_up[i];
            end
            hinl_r     <= ninl_r;
            has_line_r <= 1'b1;
            rej_cnt_r  <= '0;
            state_r    <= S_EMIT;
          end else if (bad) begin
            if (cnt_bump > max_rej_r) begin
              for (int i = 0; i < 3; i++) begin
                hp_r[i] <= np_r[i];
                hd_r[i] <= nd_up[i];
              end
              hinl_r    <= ninl_r;
              rej_cnt_r <= '0;
            end else begin
              rej_cnt_r <= cnt_bump;
              jump_r    <= 1'b1;
            end
            state_r <= S_EMIT;
          end else begin
            rej_cnt_r <= '0;
            if (mode_r[sjr_pkg::MODE_SMOOTH]) begin
              state_r <= S_PB0;
            end else begin
              for (int i = 0; i < 3; i++) begin
                hp_r[i] <= np_r[i];
                hd_r[i] <= nd_r[i];
              end
              state_r <= S_FIX;
            end
          end
        end

        // Point blend with round half up.
        S_PB0: state_r <= S_PB1;
        S_PB1: begin
          acc_r   <= prod_r[49:0];
          state_r <= S_PB2;
        end
        S_PB2: begin
          hp_r[idx_r] <= 32'((blend_sum + 50'sd32768) >>> 16);
          idx_r       <= last_idx ? 2'd0 : idx_r + 2'd1;
          state_r     <= last_idx ? S_DB0 : S_PB0;
        end

        // Direction blend in Q.30.
        S_DB0: state_r <= S_DB1;
        S_DB1: begin
          acc_r   <= prod_r[49:0];
          state_r <= S_DB2;
        end
        S_DB2: begin
          b_r[idx_r] <= blend_sum[31:0];
          idx_r      <= last_idx ? 2'd0 : idx_r + 2'd1;
          state_r    <= last_idx ? S_BZERO : S_DB0;
        end
        S_BZERO: begin
          if (b_r[0] == '0 && b_r[1] == '0 && b_r[2] == '0) begin
            for (int i = 0; i < 3; i++) b_r[i] <= {hd_r[i], 16'd0};
          end
          ss_r    <= '0;
          state_r <= S_SSQ;
        end

        // Squared length, then its root.
        S_SSQ: state_r <= S_SSQ_ACC;
        S_SSQ_ACC: begin
          ss_r    <= ss_r + prod_r[63:0];
          idx_r   <= last_idx ? 2'd0 : idx_r + 2'd1;
          state_r <= last_idx ? S_SQRT : S_SSQ;
        end
        S_SQRT: state_r <= S_SQRT_WAIT;
        S_SQRT_WAIT: begin
          if (sqrt_done) begin
            n_r     <= sqrt_root;
            state_r <= S_DIV_INIT;
          end
        end

        // Renormalize: |b| * 16384 / n, rounded, one quotient bit a cycle.
        S_DIV_INIT: begin
          if (n_r == '0) begin
            hd_r[idx_r] <= '0;
            idx_r       <= last_idx ? 2'd0 : idx_r + 2'd1;
            state_r     <= last_idx ? S_FIX : S_DIV_INIT;
          end else begin
            rem_r   <= 46'({b_abs[30:0], 14'd0}) + 46'(n_r >> 1);
            den_r   <= {n_r, 14'd0};
            q_r     <= '0;
            dcnt_r  <= '0;
            state_r <= S_DIV;
          end
        end
        S_DIV: begin
          if (rem_r >= den_r) begin
            rem_r <= rem_r - den_r;
            q_r   <= {q_r[13:0], 1'b1};
          end else begin
            q_r <= {q_r[13:0], 1'b0};
          end
          den_r  <= den_r >> 1;
          dcnt_r <= dcnt_r + 4'd1;
          if (dcnt_r == 4'(sjr_pkg::DIV_STEPS - 1)) state_r <= S_DIV_END;
        end
        S_DIV_END: begin
          hd_r[idx_r] <= b_r[idx_r][31] ? -{1'b0, q_r} : {1'b0, q_r};
          idx_r       <= last_idx ? 2'd0 : idx_r + 2'd1;
          state_r     <= last_idx ? S_FIX : S_DIV_INIT;
        end

        // Turn upward, optionally force vertical, take inliers.
        S_FIX: begin
          if (mode_r[sjr_pkg::MODE_FORCE]) begin
            hd_r[0] <= '0;
            hd_r[1] <= '0;
            hd_r[2] <= 16'(sjr_pkg::ONE_Q14);
          end else if (hd_r[2][15]) begin
            for (int i = 0; i < 3; i++) hd_r[i] <= -hd_r[i];
          end
          hinl_r  <= ninl_r;
          state_r <= S_EMIT;
        end

        // Load the result beat once the output register is free.
        S_EMIT: begin
          if (!out_valid || out_ready) begin
            out_valid        <= 1'b1;
            out_success      <= has_line_r;
            out_jump_flag    <= jump_r;
            out_point_x      <= has_line_r ? hp_r[0] : '0;
            out_point_y      <= has_line_r ? hp_r[1] : '0;
            out_point_z      <= has_line_r ? hp_r[2] : '0;
            out_dir_x        <= has_line_r ? hd_r[0] : '0;
            out_dir_y        <= has_line_r ? hd_r[1] : '0;
            out_dir_z        <= has_line_r ? hd_r[2][14:0] : '0;
            out_vertical_cos <= has_line_r ? hd_r[2][14:0] : '0;
            out_inliers      <= has_line_r ? hinl_r : '0;
            out_reject_count <= rej_cnt_r;
            state_r          <= S_IDLE;
          end
        end

        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

@@ sv/sjr_checker.sv @@
`timescale 1ns / 1ps

// Port-level checks of the line smoother.
module sjr_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic               out_success,
  input logic               out_jump_flag,
  input logic signed [31:0] out_point_x,
  input logic [14:0]        out_dir_z,
  input logic [14:0]        out_vertical_cos,
  input logic [15:0]        out_inliers
);

  // A result beat is held until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result beat dropped before it was taken");

  // The block is busy right after it takes an input beat.
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input ready right after an accepted beat");

  // A rejected jump still reports the held line.
  a_jump_has_line: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_jump_flag |-> out_success)
    else $error("jump flag without a held line");

  // Without a line all line fields read zero.
  a_no_line_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_success |-> out_point_x == '0 && out_inliers == '0 &&
    out_vertical_cos == '0)
    else $error("line fields not zero without a line");

  // The direction is upward, so its z equals the vertical cosine.
  a_vertical: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_dir_z == out_vertical_cos)
    else $error("vertical cosine differs from direction z");

endmodule

bind axis_smoothing_jump_reject_core sjr_checker u_sjr_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_valid),
  .in_ready         (in_ready),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_success      (out_success),
  .out_jump_flag    (out_jump_flag),
  .out_point_x      (out_point_x),
  .out_dir_z        (out_dir_z),
  .out_vertical_cos (out_vertical_cos),
  .out_inliers      (out_inliers)
);

@@ sim/testbench.sv @@
`timescale 1ns / 1ps

module testbench;

  // One input frame and one smoothed-line result.
  typedef struct {
    logic [1:0]         action;
    logic signed [31:0] p [3];
    logic signed [15:0] d [3];
    logic [15:0]        inl;
  } frame_t;

  typedef struct {
    logic               success;
    logic               jump;
    logic signed [31:0] p [3];
    logic signed [15:0] dx, dy;
    logic [14:0]        dz, vcos;
    logic [15:0]        inl;
    logic [7:0]         rcount;
  } line_res_t;

  logic clk, rst_n;
  logic cfg_valid, cfg_ready;
  logic [2:0] cfg_index;
  logic [31:0] cfg_data;
  logic in_valid, in_ready;
  logic [1:0] in_action;
  logic signed [31:0] in_new_point_x, in_new_point_y, in_new_point_z;
  logic signed [15:0] in_new_dir_x, in_new_dir_y, in_new_dir_z;
  logic [15:0] in_new_inliers;
  logic out_valid, out_ready, out_success, out_jump_flag;
  logic signed [31:0] out_point_x, out_point_y, out_point_z;
  logic signed [15:0] out_dir_x, out_dir_y;
  logic [14:0] out_dir_z, out_vertical_cos;
  logic [15:0] out_inliers;
  logic [7:0] out_reject_count;

  axis_smoothing_jump_reject_core dut (.*);

  // Predictor copy of the configuration and the held line.
  logic [2:0] mode_q;
  longint     max_jump_q, cos_q, max_rej_q, pt_alpha_q, dir_alpha_q;
  int         held_p [3];
  int         held_d [3];
  int         held_inl, rej_cnt;
  bit         has_line;

  line_res_t expected_lines [$];
  int        mismatches;
  int        hold_cycles;
  bit        hold_req;
  bit        no_idle;

  // Clock and run limit.
  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("Mismatches found");
    $finish;
  end

  function automatic longint unsigned root64(longint unsigned s);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > s) b >>= 2;
    while (b != 0) begin
      if (s >= r + b) begin
        s -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic void clear_line();
    for (int i = 0; i < 3; i++) begin
      held_p[i] = 0;
      held_d[i] = 0;
    end
    held_inl = 0;
    has_line = 0;
    rej_cnt = 0;
  endfunction

  function automatic void point_up();
    if (held_d[2] < 0)
      for (int i = 0; i < 3; i++) held_d[i] = -held_d[i];
  endfunction

  function automatic void adopt_line(int np [3], int nd [3], int inl);
    for (int i = 0; i < 3; i++) begin
      held_p[i] = np[i];
      held_d[i] = nd[i];
    end
    point_up();
    held_inl = inl;
  endfunction

  function automatic line_res_t held_result(bit ok, bit jump);
    line_res_t r;
    int z;
    z = held_d[2] < 0 ? -held_d[2] : held_d[2];
    if (z > int'(sjr_pkg::ONE_Q14)) z = int'(sjr_pkg::ONE_Q14);
    r.success = ok;
    r.jump = jump;
    for (int i = 0; i < 3; i++) r.p[i] = ok ? held_p[i] : 0;
    r.dx = ok ? held_d[0][15:0] : '0;
    r.dy = ok ? held_d[1][15:0] : '0;
    r.dz = ok ? held_d[2][14:0] : '0;
    r.vcos = ok ? z[14:0] : '0;
    r.inl = ok ? held_inl[15:0] : '0;
    r.rcount = rej_cnt[7:0];
    return r;
  endfunction

  // Advances the held line by one frame and returns the line reported for it.
  function automatic line_res_t track_line(frame_t f);
    int np [3];
    int nd [3];
    longint dd, dot, pa, da, v;
    longint b [3];
    longint unsigned a, ss, s, n;
    int q;
    bit lat_bad, ang_bad;
    if (f.action == sjr_pkg::ACT_CLEAR) begin
      clear_line();
      return held_result(0, 0);
    end
    if (f.action != sjr_pkg::ACT_LINE) begin
      if (rej_cnt < 255) rej_cnt++;
      return held_result(has_line, 0);
    end
    for (int i = 0; i < 3; i++) begin
      np[i] = f.p[i];
      nd[i] = f.d[i];
      if (nd[i] > 16384) nd[i] = 16384;
      if (nd[i] < -16384) nd[i] = -16384;
    end
    if (!has_line) begin
      adopt_line(np, nd, int'(f.inl));
      has_line = 1;
      rej_cnt = 0;
      return held_result(1, 0);
    end
    if (mode_q[sjr_pkg::MODE_REJECT]) begin
      lat_bad = 0;
      ss = 0;
      dot = 0;
      for (int i = 0; i < 3; i++) begin
        dd = longint'(np[i]) - longint'(held_p[i]);
        a = dd < 0 ? -dd : dd;
        if (a > max_jump_q) lat_bad = 1;
        else ss += a * a;
        dot += longint'(nd[i]) * longint'(held_d[i]);
      end
      if (!lat_bad) lat_bad = ss > longint'(max_jump_q * max_jump_q);
      if (dot > (64'sd1 << 28)) dot = 64'sd1 << 28;
      if (dot < -(64'sd1 << 28)) dot = -(64'sd1 << 28);
      ang_bad = dot < cos_q * longint'(sjr_pkg::ONE_Q14);
      if (lat_bad || ang_bad) begin
        if (rej_cnt < 255) rej_cnt++;
        if (rej_cnt > max_rej_q) begin
          adopt_line(np, nd, int'(f.inl));
          rej_cnt = 0;
          return held_result(1, 0);
        end
        return held_result(1, 1);
      end
    end
    rej_cnt = 0;
    if (mode_q[sjr_pkg::MODE_SMOOTH]) begin
      pa = pt_alpha_q > sjr_pkg::ONE_Q16 ? sjr_pkg::ONE_Q16 : pt_alpha_q;
      da = dir_alpha_q > sjr_pkg::ONE_Q16 ? sjr_pkg::ONE_Q16 : dir_alpha_q;
      s = 0;
      for (int i = 0; i < 3; i++) begin
        v = longint'(held_p[i]) * (sjr_pkg::ONE_Q16 - pa) + longint'(np[i]) * pa;
        held_p[i] = int'((v + 32768) >>> 16);
        b[i] = longint'(held_d[i]) * (sjr_pkg::ONE_Q16 - da) + longint'(nd[i]) * da;
      end
      if (b[0] == 0 && b[1] == 0 && b[2] == 0)
        for (int i = 0; i < 3; i++) b[i] = longint'(held_d[i]) * sjr_pkg::ONE_Q16;
      for (int i = 0; i < 3; i++) begin
        a = b[i] < 0 ? -b[i] : b[i];
        s += a * a;
      end
      n = root64(s);
      for (int i = 0; i < 3; i++) begin
        if (n == 0) begin
          held_d[i] = 0;
        end else begin
          a = b[i] < 0 ? -b[i] : b[i];
          q = int'((a * sjr_pkg::ONE_Q14 + n / 2) / n);
          held_d[i] = b[i] < 0 ? -q : q;
        end
      end
      point_up();
    end else begin
      for (int i = 0; i < 3; i++) begin
        held_p[i] = np[i];
        held_d[i] = nd[i];
      end
      point_up();
    end
    if (mode_q[sjr_pkg::MODE_FORCE]) begin
      held_d[0] = 0;
      held_d[1] = 0;
      held_d[2] = int'(sjr_pkg::ONE_Q14);
    end
    held_inl = int'(f.inl);
    return held_result(1, 0);
  endfunction

  // Sends one frame beat; valid stays high across back-to-back beats.
  task automatic send_frame(frame_t f);
    int gap;
    gap = no_idle ? 0 : ($urandom_range(0, 9) < 6 ? 0 :
          ($urandom_range(0, 9) < 8 ? $urandom_range(1, 4) : $urandom_range(10, 40)));
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_action <= f.action;
    in_new_point_x <= f.p[0];
    in_new_point_y <= f.p[1];
    in_new_point_z <= f.p[2];
    in_new_dir_x <= f.d[0];
    in_new_dir_y <= f.d[1];
    in_new_dir_z <= f.d[2];
    in_new_inliers <= f.inl;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    expected_lines = {expected_lines, track_line(f)};
  endtask

  task automatic stop_frames();
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Waits for every expected line, then lets a slow beat finish.
  task automatic wait_drained();
    stop_frames();
    while (expected_lines.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  // Offers one register write and waits until it is taken.
  task automatic write_reg(logic [2:0] idx, longint val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val[31:0];
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      sjr_pkg::CFG_MODE:      mode_q = val[2:0];
      sjr_pkg::CFG_MAX_JUMP:  max_jump_q = longint'(val[30:0]);
      sjr_pkg::CFG_COS_ANGLE: cos_q = longint'(signed'(val[15:0]));
      sjr_pkg::CFG_MAX_REJ:   max_rej_q = longint'(val[7:0]);
      sjr_pkg::CFG_PT_ALPHA:  pt_alpha_q = longint'(val[16:0]);
      sjr_pkg::CFG_DIR_ALPHA: dir_alpha_q = longint'(val[16:0]);
      default: ;
    endcase
  endtask

  task automatic set_config(longint m, longint j, longint c, longint r, longint pa,
                            longint da);
    write_reg(sjr_pkg::CFG_MODE, m);
    write_reg(sjr_pkg::CFG_MAX_JUMP, j);
    write_reg(sjr_pkg::CFG_COS_ANGLE, c);
    write_reg(sjr_pkg::CFG_MAX_REJ, r);
    write_reg(sjr_pkg::CFG_PT_ALPHA, pa);
    write_reg(sjr_pkg::CFG_DIR_ALPHA, da);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic frame_t line_frame(int x, int y, int z, int dx, int dy, int dz,
                                       int inl);
    frame_t f;
    f.action = sjr_pkg::ACT_LINE;
    f.p[0] = x;
    f.p[1] = y;
    f.p[2] = z;
    f.d[0] = 16'(dx);
    f.d[1] = 16'(dy);
    f.d[2] = 16'(dz);
    f.inl = 16'(inl);
    return f;
  endfunction

  function automatic frame_t plain_frame(logic [1:0] act);
    frame_t f;
    f = line_frame(0, 0, 0, 0, 0, 0, 0);
    f.action = act;
    return f;
  endfunction

  function automatic int rand_dir();
    return int'($urandom_range(0, 32768)) - 16384;
  endfunction

  // Mostly lines close to the held one, with some wild lines, gaps and clears.
  function automatic frame_t random_frame(int spread);
    frame_t f;
    int sel, c;
    longint v;
    sel = $urandom_range(0, 99);
    if (sel < 3) return plain_frame(sjr_pkg::ACT_CLEAR);
    if (sel < 15) return plain_frame(sjr_pkg::ACT_NOLINE);
    f = plain_frame(sjr_pkg::ACT_LINE);
    f.inl = 16'($urandom);
    if (sel < 82 && has_line) begin
      for (int i = 0; i < 3; i++) begin
        v = longint'(held_p[i]) + int'($urandom_range(0, 2 * spread)) - spread;
        if (v > 64'sh7FFFFFFF) v = 64'sh7FFFFFFF;
        if (v < -64'sh80000000) v = -64'sh80000000;
        f.p[i] = v[31:0];
        c = held_d[i] + int'($urandom_range(0, 3000)) - 1500;
        if (c > 16384) c = 16384;
        if (c < -16384) c = -16384;
        f.d[i] = 16'(c);
      end
    end else begin
      for (int i = 0; i < 3; i++) begin
        f.p[i] = $urandom;
        f.d[i] = 16'(rand_dir());
      end
    end
    return f;
  endfunction

  task automatic send_random(int count, int spread);
    for (int k = 0; k < count; k++) begin
      if (k % 40 == 0) no_idle = $urandom_range(0, 3) == 0;
      send_frame(random_frame(spread));
    end
    no_idle = 0;
  endtask

  // Field extremes, each action, first line, flip upward, both rejects, adoption.
  task automatic test_directed();
    send_frame(plain_frame(sjr_pkg::ACT_NOLINE));
    send_frame(plain_frame(sjr_pkg::ACT_CLEAR));
    send_frame(line_frame(32'h7FFFFFFF, 32'h80000000, 0, -16384, 0, -16384, 65535));
    send_frame(line_frame(32'h7FFFFFFF, 32'h80000000, 0, 16384, 0, 0, 0));
    for (int k = 0; k < 6; k++)
      send_frame(line_frame(0, 0, 0, -11585, 0, 11585, k));
    send_frame(line_frame(1000, -2000, 3000, 100, -200, 16380, 7));
    send_frame(line_frame(-1000, 2000, -3000, -16384, 16384, 16384, 12));
    send_frame(plain_frame(sjr_pkg::ACT_NOLINE));
    send_frame(line_frame(20000, 0, 0, 0, 0, -16384, 3));
    send_frame(plain_frame(sjr_pkg::ACT_CLEAR));
    send_frame(plain_frame(sjr_pkg::ACT_NOLINE));
    send_frame(line_frame(0, 0, 0, 0, 0, 0, 1));
    send_frame(line_frame(0, 0, 0, 0, 0, 0, 2));
    wait_drained();
  endtask

  // Counter saturation: many frames without a line and no adoption limit.
  task automatic test_counter_saturation();
    set_config(3, 32768, 16135, 255, 19661, 19661);
    send_frame(line_frame(0, 0, 0, 0, 0, 16384, 9));
    no_idle = 1;
    repeat (258) send_frame(plain_frame(sjr_pkg::ACT_NOLINE));
    send_frame(line_frame(32'h40000000, 0, 0, 0, 0, 16384, 9));
    no_idle = 0;
    wait_drained();
  endtask

  // The receiver holds off while frames keep coming, so the block stalls its input.
  task automatic test_backpressure();
    no_idle = 1;
    hold_req <= 1'b1;
    @(posedge clk);
    hold_req <= 1'b0;
    repeat (12) send_frame(random_frame(20000));
    no_idle = 0;
    wait_drained();
  endtask

  task automatic test_random_phases();
    send_random(80, 30000);
    wait_drained();
    set_config(7, 2147483647, -16384, 1, 65536, 65536);
    send_random(70, 1 << 30);
    wait_drained();
    set_config(0, 0, 16384, 255, 0, 0);
    send_random(70, 50000);
    wait_drained();
    set_config(3, 100000, 15000, 3, 30000, 45000);
    send_random(80, 70000);
    wait_drained();
    set_config(5, 65536, 16000, 2, 1, 65535);
    send_random(70, 50000);
    wait_drained();
    set_config(2, 32768, 0, 10, 65536, 0);
    send_random(70, 40000);
    wait_drained();
    set_config(1, 0, 16384, 1, 19661, 19661);
    send_random(40, 5);
    wait_drained();
  endtask

  // Receiver: random stalls, long hold-offs on request.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      hold_cycles <= 0;
    end else if (hold_req) begin
      hold_cycles <= 600;
      out_ready <= 1'b0;
    end else if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_ready <= 1'b0;
    end else if (no_idle) begin
      out_ready <= 1'b1;
    end else begin
      out_ready <= $urandom_range(0, 9) < 7 ? 1'b1 : ($urandom_range(0, 19) == 0 ? 1'b0 :
                   $urandom_range(0, 1));
    end
  end

  task automatic report_mismatch(string field, longint got, longint want);
    $display("mismatch at %0t: %s got %0d expected %0d", $realtime, field, got, want);
    mismatches++;
  endtask

  // Compare each result beat with the oldest expected line.
  always @(posedge clk) begin
    line_res_t e;
    if (rst_n && out_valid && out_ready) begin
      if (expected_lines.size() == 0) begin
        report_mismatch("unexpected beat", 1, 0);
      end else begin
        e = expected_lines.pop_front();
        if (out_success !== e.success) report_mismatch("success", out_success, e.success);
        if (out_jump_flag !== e.jump) report_mismatch("jump_flag", out_jump_flag, e.jump);
        if (out_point_x !== e.p[0]) report_mismatch("point_x", out_point_x, e.p[0]);
        if (out_point_y !== e.p[1]) report_mismatch("point_y", out_point_y, e.p[1]);
        if (out_point_z !== e.p[2]) report_mismatch("point_z", out_point_z, e.p[2]);
        if (out_dir_x !== e.dx) report_mismatch("dir_x", out_dir_x, e.dx);
        if (out_dir_y !== e.dy) report_mismatch("dir_y", out_dir_y, e.dy);
        if (out_dir_z !== e.dz) report_mismatch("dir_z", out_dir_z, e.dz);
        if (out_vertical_cos !== e.vcos)
          report_mismatch("vertical_cos", out_vertical_cos, e.vcos);
        if (out_inliers !== e.inl) report_mismatch("inliers", out_inliers, e.inl);
        if (out_reject_count !== e.rcount)
          report_mismatch("reject_count", out_reject_count, e.rcount);
      end
    end
  end

  initial begin
    rst_n = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_valid = 1'b0;
    in_action = sjr_pkg::ACT_NOLINE;
    in_new_point_x = '0;
    in_new_point_y = '0;
    in_new_point_z = '0;
    in_new_dir_x = '0;
    in_new_dir_y = '0;
    in_new_dir_z = '0;
    in_new_inliers = '0;
    mismatches = 0;
    hold_req = 0;
    no_idle = 0;
    mode_q = sjr_pkg::RST_MODE;
    max_jump_q = longint'(sjr_pkg::RST_MAX_JUMP);
    cos_q = longint'(sjr_pkg::RST_COS_ANGLE);
    max_rej_q = longint'(sjr_pkg::RST_MAX_REJ);
    pt_alpha_q = longint'(sjr_pkg::RST_ALPHA);
    dir_alpha_q = longint'(sjr_pkg::RST_ALPHA);
    clear_line();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_backpressure();
    test_random_phases();
    test_counter_saturation();
    wait_drained();
    if (mismatches == 0 && expected_lines.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
